FILE: hw/rtl/sortab_pkg.sv
// Shared types and constants for the sorted table block.
`default_nettype none

package sortab_pkg;

  // Table depth and derived index widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Item field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ENTRY_W  = 7;

  localparam int unsigned IN_FIELDS_W  = OP_W + KEY_W + TAG_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = STAT_W + POS_W + ENTRY_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  // Where the reported position comes from
  typedef enum logic [1:0] {
    POS_KEEP = 2'd0,
    POS_ZERO = 2'd1,
    POS_IDX  = 2'd2
  } pos_sel_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     ins_shift;
    logic     ins_place;
    logic     scan_next;
    logic     shift_step;
    logic     shift_end;
    logic     finish;
    status_e  res_status;
    pos_sel_e pos_sel;
    logic     load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] cur_op;
    logic            full;
    logic            ins_greater;
    logic            scan_end;
    logic            scan_hit;
    logic            shift_more;
    logic            out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sortab_dp.sv
// Datapath: entry memory, index and count registers, result and output registers.
`default_nettype none

module sortab_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [sortab_pkg::IN_DATA_W-1:0]    in_tdata_i,
  input  sortab_pkg::cmd_t                    cmd_i,
  output sortab_pkg::status_t                 status_o,
  output logic                                out_tvalid_o,
  input  wire                                 out_tready_i,
  output logic [sortab_pkg::OUT_DATA_W-1:0]   out_tdata_o
);

  localparam int unsigned CNT_W = sortab_pkg::CNT_W;
  localparam int unsigned IDX_W = sortab_pkg::IDX_W;

  // Input fields
  logic [sortab_pkg::OP_W-1:0]         in_op;
  logic signed [sortab_pkg::KEY_W-1:0] in_key;
  logic [sortab_pkg::TAG_W-1:0]        in_tag;

  assign in_op  = in_tdata_i[sortab_pkg::OP_W-1:0];
  assign in_key = in_tdata_i[sortab_pkg::OP_W +: sortab_pkg::KEY_W];
  assign in_tag = in_tdata_i[sortab_pkg::OP_W + sortab_pkg::KEY_W +: sortab_pkg::TAG_W];

  logic [sortab_pkg::OP_W-1:0]         op_q;
  logic signed [sortab_pkg::KEY_W-1:0] key_q;
  logic [sortab_pkg::TAG_W-1:0]        tag_q;
  logic [CNT_W-1:0]                    idx_q, idx_d;
  logic [CNT_W-1:0]                    count_q, count_d;
  sortab_pkg::status_e                 res_status_q;
  logic [sortab_pkg::POS_W-1:0]        res_pos_q;
  logic                                out_valid_q, out_valid_d;
  logic [sortab_pkg::OUT_DATA_W-1:0]   out_data_q;

  // Entry memory, one read and one write port, registered read data
  sortab_pkg::entry_t mem [sortab_pkg::CAPACITY];
  sortab_pkg::entry_t rdata_q;
  sortab_pkg::entry_t wdata;
  logic [CNT_W-1:0]   raddr;
  logic               we;

  always_comb begin
    if (cmd_i.accept) begin
      raddr = (in_op == sortab_pkg::OP_INSERT) ? count_q - CNT_W'(1) : '0;
    end else if (cmd_i.ins_shift) begin
      raddr = idx_q - CNT_W'(2);
    end else if (cmd_i.shift_step) begin
      raddr = idx_q + CNT_W'(2);
    end else begin
      raddr = idx_q + CNT_W'(1);
    end
  end

  assign we = cmd_i.ins_shift | cmd_i.ins_place | cmd_i.shift_step;

  always_comb begin
    if (cmd_i.ins_place) begin
      wdata.key = key_q;
      wdata.tag = tag_q;
    end else begin
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q[IDX_W-1:0]] <= wdata;
    end
    rdata_q <= mem[raddr[IDX_W-1:0]];
  end

  // Index and count
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.accept) begin
      idx_d = (in_op == sortab_pkg::OP_INSERT) ? count_q : '0;
    end else if (cmd_i.ins_shift) begin
      idx_d = idx_q - CNT_W'(1);
    end else if (cmd_i.scan_next || cmd_i.shift_step) begin
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_place) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.shift_end) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Output register, free again once the downstream side takes the item
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.accept) begin
      op_q  <= in_op;
      key_q <= in_key;
      tag_q <= in_tag;
    end
    case (cmd_i.pos_sel)
      sortab_pkg::POS_ZERO: res_pos_q <= '0;
      sortab_pkg::POS_IDX:  res_pos_q <= sortab_pkg::POS_W'(idx_q);
      default:              res_pos_q <= res_pos_q;
    endcase
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.load_out) begin
      out_data_q <= sortab_pkg::OUT_DATA_W'({sortab_pkg::ENTRY_W'(count_d), res_pos_q,
                                             res_status_q});
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;

  // Status to the controller
  always_comb begin
    status_o.in_op       = in_op;
    status_o.cur_op      = op_q;
    status_o.full        = count_q >= CNT_W'(sortab_pkg::CAPACITY);
    status_o.ins_greater = (idx_q != '0) && (rdata_q.key > key_q);
    status_o.scan_end    = idx_q >= count_q;
    status_o.scan_hit    = rdata_q.tag == tag_q;
    status_o.shift_more  = (idx_q + CNT_W'(1)) < count_q;
    status_o.out_free    = !out_valid_q || out_tready_i;
  end

  // Count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(sortab_pkg::CAPACITY))
    else $error("entry count above capacity");

  // Writes never land beyond the table
  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> idx_q < CNT_W'(sortab_pkg::CAPACITY))
    else $error("write index out of range");

  // Count moves only on a placement or the end of a removal
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.ins_place || cmd_i.shift_end) |=> $stable(count_q))
    else $error("count changed without insert or remove");

endmodule

`default_nettype wire

FILE: hw/rtl/sortab_ctrl.sv
// Controller: sequences insert shifts, tag scans and remove shifts.
`default_nettype none

module sortab_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_tvalid_i,
  output logic                 in_tready_o,
  input  sortab_pkg::status_t  status_i,
  output sortab_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_INS   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_tready_o = state_q == S_IDLE;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_status = sortab_pkg::STAT_OK;
    cmd_o.pos_sel    = sortab_pkg::POS_KEEP;
    case (state_q)
      S_IDLE: begin
        if (in_tvalid_i) begin
          cmd_o.accept = 1'b1;
          case (status_i.in_op)
            sortab_pkg::OP_INSERT: begin
              if (status_i.full) begin
                cmd_o.finish     = 1'b1;
                cmd_o.res_status = sortab_pkg::STAT_FULL;
                cmd_o.pos_sel    = sortab_pkg::POS_ZERO;
                state_d          = S_DONE;
              end else begin
                state_d = S_INS;
              end
            end
            sortab_pkg::OP_SEARCH,
            sortab_pkg::OP_REMOVE: state_d = S_SCAN;
            default: begin
              // unused code: report the count only
              cmd_o.finish  = 1'b1;
              cmd_o.pos_sel = sortab_pkg::POS_ZERO;
              state_d       = S_DONE;
            end
          endcase
        end
      end
      S_INS: begin
        if (status_i.ins_greater) begin
          cmd_o.ins_shift = 1'b1;
        end else begin
          cmd_o.ins_place = 1'b1;
          cmd_o.finish    = 1'b1;
          cmd_o.pos_sel   = sortab_pkg::POS_IDX;
          state_d         = S_DONE;
        end
      end
      S_SCAN: begin
        if (status_i.scan_end) begin
          cmd_o.finish     = 1'b1;
          cmd_o.res_status = sortab_pkg::STAT_NOT_FOUND;
          cmd_o.pos_sel    = sortab_pkg::POS_ZERO;
          state_d          = S_DONE;
        end else if (status_i.scan_hit) begin
          cmd_o.pos_sel = sortab_pkg::POS_IDX;
          if (status_i.cur_op == sortab_pkg::OP_REMOVE) begin
            state_d = S_SHIFT;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = S_DONE;
          end
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_SHIFT: begin
        if (status_i.shift_more) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.shift_end = 1'b1;
          cmd_o.finish    = 1'b1;
          state_d         = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Every finished operation hands its result over from the done state
  a_finish_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_DONE)
    else $error("finished operation did not reach done state");

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_table_insert_search_delete_top.sv
// Top level of the sorted table: stream ports, controller and datapath.
// Inserts, searches and removes walk the entry memory one slot a cycle, with one read
// and one write a cycle. One item at a time; the next item is taken once the result
// sits in the output register. Reset clears the count, the output valid flag and the
// control state only; entry memory is not cleared and needs no clearing pass.
`default_nettype none

module sorted_table_insert_search_delete_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Item in
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // from bit 0: operation[1:0], sort_key[33:2], tag[65:34], zero pad
  input  wire  [sortab_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Result out
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // from bit 0: status[1:0], position[7:2], entry_count[14:8], zero pad
  output logic [sortab_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  sortab_pkg::cmd_t    cmd;
  sortab_pkg::status_t status;

  // Sequencer: one step of shift or scan per cycle
  sortab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Entry memory, indices, count and the result register
  sortab_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_tdata_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
